// ----- rtl/gdds_pkg.sv -----
// Shared types and constants for the grid diffusion/decay stencil core.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gdds_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int VAL_BITS      = 16;
  localparam int WGT_BITS      = 16;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
  localparam int GW_BITS       = COL_BITS + 1;
  localparam int GH_BITS       = ROW_BITS + 1;
  localparam int LINE_DEPTH    = 2 * MAX_WIDTH;
  localparam int ADDR_BITS     = $clog2(LINE_DEPTH);
  localparam int SUM_BITS      = VAL_BITS + 2;
  localparam int CNT_BITS      = 3;
  localparam int MIX_BITS      = VAL_BITS + WGT_BITS;
  localparam int PROD_BITS     = MIX_BITS + WGT_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // Divide by three as floor(s * RECIP3 / 2^RECIP3_SHIFT); exact for s < 2^19.
  localparam int RECIP3_BITS  = 19;
  localparam int RECIP3_SHIFT = 20;
  localparam logic [RECIP3_BITS-1:0] RECIP3 = RECIP3_BITS'(349526);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SELF_WEIGHT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_FACTOR = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_FLOOR   = 3'd4;

  // Register reset values.
  localparam logic [GW_BITS-1:0]  RST_GRID_WIDTH   = GW_BITS'(64);
  localparam logic [GH_BITS-1:0]  RST_GRID_HEIGHT  = GH_BITS'(64);
  localparam logic [WGT_BITS-1:0] RST_SELF_WEIGHT  = WGT_BITS'(52429);
  localparam logic [WGT_BITS-1:0] RST_DECAY_FACTOR = WGT_BITS'(62259);
  localparam logic [VAL_BITS-1:0] RST_ZERO_FLOOR   = VAL_BITS'(13);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_SELF,
    ST_A_LEFT,
    ST_A_RIGHT,
    ST_A_UP,
    ST_A_GO,
    ST_WRITE,
    ST_B_SELF,
    ST_B_LEFT,
    ST_B_UP,
    ST_B_GO,
    ST_C_INIT,
    ST_C_UP,
    ST_C_GO
  } state_t;

  // Line store read selects: previous or current row, column offset.
  typedef enum logic [2:0] {
    RD_PRV_X,
    RD_PRV_XM1,
    RD_PRV_XP1,
    RD_CUR_X,
    RD_CUR_XM1,
    RD_CUR_XM2
  } rd_sel_t;

  // Which cell a blend belongs to, relative to the current input cell.
  typedef enum logic [1:0] {
    TAG_UP,
    TAG_LEFT,
    TAG_SELF
  } tag_t;

  typedef struct packed {
    logic    load;
    logic    init_one;
    logic    init_zero;
    logic    self_from_v;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    rd_to_self;
    logic    wr_en;
    logic    start;
    tag_t    tag;
  } cmd_t;

  typedef struct packed {
    logic up;
    logic up2;
    logic x_gt0;
    logic x_gt1;
    logic right;
    logic last_row;
    logic last_col;
    logic pipe_free;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/gdds_in_if.sv -----
// Input channel: one Q8.8 cell value per beat.
// Depends on gdds_pkg for the value width.
`timescale 1ns / 1ps
`default_nettype none

interface gdds_in_if;
  logic                          valid;
  logic                          ready;
  logic [gdds_pkg::VAL_BITS-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/gdds_out_if.sv -----
// Result channel: one finished cell with its coordinates per beat.
// Depends on gdds_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface gdds_out_if;
  logic                          valid;
  logic                          ready;
  logic [gdds_pkg::COL_BITS-1:0] cell_x;
  logic [gdds_pkg::ROW_BITS-1:0] cell_y;
  logic [gdds_pkg::VAL_BITS-1:0] new_value;
  logic                          frame_done;

  modport source (output valid, output cell_x, output cell_y, output new_value,
                  output frame_done, input ready);
  modport sink   (input valid, input cell_x, input cell_y, input new_value,
                  input frame_done, output ready);
endinterface

`default_nettype wire

// ----- rtl/gdds_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gdds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gdds_ctrl.sv -----
// Sequencer for the stencil core: gathers neighbours one line store read
// per cycle and launches blends. Depends on gdds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gdds_pkg::status_t status,
  output gdds_pkg::cmd_t    cmd
);

  gdds_pkg::state_t state;
  gdds_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gdds_pkg::ST_IDLE: begin
        if (in_valid) state_next = gdds_pkg::ST_A_SELF;
      end
      gdds_pkg::ST_A_SELF: begin
        state_next = status.up ? gdds_pkg::ST_A_LEFT : gdds_pkg::ST_WRITE;
      end
      gdds_pkg::ST_A_LEFT:  state_next = gdds_pkg::ST_A_RIGHT;
      gdds_pkg::ST_A_RIGHT: state_next = gdds_pkg::ST_A_UP;
      gdds_pkg::ST_A_UP:    state_next = gdds_pkg::ST_A_GO;
      gdds_pkg::ST_A_GO: begin
        if (status.pipe_free) state_next = gdds_pkg::ST_WRITE;
      end
      gdds_pkg::ST_WRITE: begin
        if (status.last_row && status.x_gt0) begin
          state_next = gdds_pkg::ST_B_SELF;
        end else if (status.last_row && status.last_col) begin
          state_next = gdds_pkg::ST_C_INIT;
        end else begin
          state_next = gdds_pkg::ST_IDLE;
        end
      end
      gdds_pkg::ST_B_SELF: state_next = gdds_pkg::ST_B_LEFT;
      gdds_pkg::ST_B_LEFT: state_next = gdds_pkg::ST_B_UP;
      gdds_pkg::ST_B_UP:   state_next = gdds_pkg::ST_B_GO;
      gdds_pkg::ST_B_GO: begin
        if (status.pipe_free) begin
          state_next = status.last_col ? gdds_pkg::ST_C_INIT : gdds_pkg::ST_IDLE;
        end
      end
      gdds_pkg::ST_C_INIT: state_next = gdds_pkg::ST_C_UP;
      gdds_pkg::ST_C_UP:   state_next = gdds_pkg::ST_C_GO;
      gdds_pkg::ST_C_GO: begin
        if (status.pipe_free) state_next = gdds_pkg::ST_IDLE;
      end
      default: state_next = gdds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = gdds_pkg::RD_PRV_X;
    cmd.tag    = gdds_pkg::TAG_UP;
    in_ready   = 1'b0;
    case (state)
      gdds_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      // Cell above: own value from the previous row, the input is its
      // lower neighbour.
      gdds_pkg::ST_A_SELF: begin
        cmd.init_one   = status.up;
        cmd.rd_en      = status.up;
        cmd.rd_sel     = gdds_pkg::RD_PRV_X;
        cmd.rd_to_self = 1'b1;
      end
      gdds_pkg::ST_A_LEFT: begin
        cmd.rd_en  = status.x_gt0;
        cmd.rd_sel = gdds_pkg::RD_PRV_XM1;
      end
      gdds_pkg::ST_A_RIGHT: begin
        cmd.rd_en  = status.right;
        cmd.rd_sel = gdds_pkg::RD_PRV_XP1;
      end
      gdds_pkg::ST_A_UP: begin
        // Two rows up still sits in the current-row half at this column.
        cmd.rd_en  = status.up2;
        cmd.rd_sel = gdds_pkg::RD_CUR_X;
      end
      gdds_pkg::ST_A_GO: begin
        cmd.start = status.pipe_free;
        cmd.tag   = gdds_pkg::TAG_UP;
      end
      gdds_pkg::ST_WRITE: begin
        cmd.wr_en = 1'b1;
      end
      // Left cell on the last row: the input is its right neighbour.
      gdds_pkg::ST_B_SELF: begin
        cmd.init_one   = 1'b1;
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = gdds_pkg::RD_CUR_XM1;
        cmd.rd_to_self = 1'b1;
      end
      gdds_pkg::ST_B_LEFT: begin
        cmd.rd_en  = status.x_gt1;
        cmd.rd_sel = gdds_pkg::RD_CUR_XM2;
      end
      gdds_pkg::ST_B_UP: begin
        cmd.rd_en  = status.up;
        cmd.rd_sel = gdds_pkg::RD_PRV_XM1;
      end
      gdds_pkg::ST_B_GO: begin
        cmd.start = status.pipe_free;
        cmd.tag   = gdds_pkg::TAG_LEFT;
      end
      // Last cell of the frame: the input itself is the centre value.
      gdds_pkg::ST_C_INIT: begin
        cmd.init_zero   = 1'b1;
        cmd.self_from_v = 1'b1;
        cmd.rd_en       = status.x_gt0;
        cmd.rd_sel      = gdds_pkg::RD_CUR_XM1;
      end
      gdds_pkg::ST_C_UP: begin
        cmd.rd_en  = status.up;
        cmd.rd_sel = gdds_pkg::RD_PRV_X;
      end
      gdds_pkg::ST_C_GO: begin
        cmd.start = status.pipe_free;
        cmd.tag   = gdds_pkg::TAG_SELF;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/gdds_dp.sv -----
// Datapath of the stencil core: configuration registers, raster counters,
// neighbour accumulation, the blend pipeline and the result register.
// Depends on gdds_pkg; drives the line store RAM ports.
`timescale 1ns / 1ps
`default_nettype none

module gdds_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  gdds_pkg::cmd_t                     cmd,
  output gdds_pkg::status_t                  status,
  input  logic [gdds_pkg::VAL_BITS-1:0]      cell_value,
  input  logic                               cfg_we,
  input  logic [gdds_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [gdds_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output logic                               mem_wr_en,
  output logic [gdds_pkg::ADDR_BITS-1:0]     mem_wr_addr,
  output logic [gdds_pkg::VAL_BITS-1:0]      mem_wr_data,
  output logic                               mem_rd_en,
  output logic [gdds_pkg::ADDR_BITS-1:0]     mem_rd_addr,
  input  logic [gdds_pkg::VAL_BITS-1:0]      mem_rd_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gdds_pkg::COL_BITS-1:0]      out_cell_x,
  output logic [gdds_pkg::ROW_BITS-1:0]      out_cell_y,
  output logic [gdds_pkg::VAL_BITS-1:0]      out_new_value,
  output logic                               out_frame_done
);

  localparam int VB = gdds_pkg::VAL_BITS;
  localparam int CB = gdds_pkg::COL_BITS;
  localparam int RB = gdds_pkg::ROW_BITS;
  localparam int SB = gdds_pkg::SUM_BITS;
  localparam int WB = gdds_pkg::WGT_BITS;
  localparam int MB = gdds_pkg::MIX_BITS;
  localparam int PB = gdds_pkg::PROD_BITS;

  // Configuration registers.
  logic [gdds_pkg::GW_BITS-1:0] grid_width;
  logic [gdds_pkg::GH_BITS-1:0] grid_height;
  logic [WB-1:0]                self_weight;
  logic [WB-1:0]                decay_factor;
  logic [VB-1:0]                zero_floor;

  logic geom_write;
  assign geom_write = cfg_we && ((cfg_index == gdds_pkg::REG_GRID_WIDTH) ||
                                 (cfg_index == gdds_pkg::REG_GRID_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= gdds_pkg::RST_GRID_WIDTH;
      grid_height  <= gdds_pkg::RST_GRID_HEIGHT;
      self_weight  <= gdds_pkg::RST_SELF_WEIGHT;
      decay_factor <= gdds_pkg::RST_DECAY_FACTOR;
      zero_floor   <= gdds_pkg::RST_ZERO_FLOOR;
    end else if (cfg_we) begin
      case (cfg_index)
        gdds_pkg::REG_GRID_WIDTH:   grid_width   <= cfg_data[gdds_pkg::GW_BITS-1:0];
        gdds_pkg::REG_GRID_HEIGHT:  grid_height  <= cfg_data[gdds_pkg::GH_BITS-1:0];
        gdds_pkg::REG_SELF_WEIGHT:  self_weight  <= cfg_data[WB-1:0];
        gdds_pkg::REG_DECAY_FACTOR: decay_factor <= cfg_data[WB-1:0];
        gdds_pkg::REG_ZERO_FLOOR:   zero_floor   <= cfg_data[VB-1:0];
        default: ;
      endcase
    end
  end

  // Geometry in use: zero acts as one, oversize values are clamped.
  logic [gdds_pkg::GW_BITS-1:0] w_eff;
  logic [gdds_pkg::GH_BITS-1:0] h_eff;

  always_comb begin
    if (grid_width == '0) begin
      w_eff = gdds_pkg::GW_BITS'(1);
    end else if (grid_width > gdds_pkg::GW_BITS'(gdds_pkg::MAX_WIDTH)) begin
      w_eff = gdds_pkg::GW_BITS'(gdds_pkg::MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height == '0) begin
      h_eff = gdds_pkg::GH_BITS'(1);
    end else if (grid_height > gdds_pkg::GH_BITS'(gdds_pkg::MAX_HEIGHT)) begin
      h_eff = gdds_pkg::GH_BITS'(gdds_pkg::MAX_HEIGHT);
    end else begin
      h_eff = grid_height;
    end
  end

  // Raster counters and the latched current cell.
  logic [CB-1:0] col_cnt;
  logic [RB-1:0] row_cnt;
  logic [CB-1:0] cur_x;
  logic [RB-1:0] cur_y;
  logic [VB-1:0] cur_v;

  logic                         wrap;
  logic [CB-1:0]                x_start;
  logic [RB-1:0]                y_start;
  logic [gdds_pkg::GW_BITS-1:0] x_inc;
  logic [gdds_pkg::GH_BITS-1:0] y_inc;

  assign wrap    = ({1'b0, col_cnt} >= w_eff) || ({1'b0, row_cnt} >= h_eff);
  assign x_start = wrap ? '0 : col_cnt;
  assign y_start = wrap ? '0 : row_cnt;
  assign x_inc   = {1'b0, x_start} + gdds_pkg::GW_BITS'(1);
  assign y_inc   = {1'b0, y_start} + gdds_pkg::GH_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (geom_write) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (cmd.load) begin
      if (x_inc < w_eff) begin
        col_cnt <= x_inc[CB-1:0];
        row_cnt <= y_start;
      end else begin
        col_cnt <= '0;
        row_cnt <= (y_inc < h_eff) ? y_inc[RB-1:0] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x <= x_start;
      cur_y <= y_start;
      cur_v <= cell_value;
    end
  end

  // Line store addressing: row parity picks the half, column the entry.
  logic                         cur_bit;
  logic                         prv_bit;
  logic [gdds_pkg::GW_BITS-1:0] x_plus1;
  logic [gdds_pkg::GH_BITS-1:0] y_plus1;
  logic                         pipe_free;

  assign cur_bit = cur_y[0];
  assign prv_bit = ~cur_y[0];
  assign x_plus1 = {1'b0, cur_x} + gdds_pkg::GW_BITS'(1);
  assign y_plus1 = {1'b0, cur_y} + gdds_pkg::GH_BITS'(1);

  always_comb begin
    status.up        = (cur_y != '0);
    status.up2       = (cur_y > RB'(1));
    status.x_gt0     = (cur_x != '0);
    status.x_gt1     = (cur_x > CB'(1));
    status.right     = (x_plus1 < w_eff);
    status.last_row  = (y_plus1 == h_eff);
    status.last_col  = (x_plus1 == w_eff);
    status.pipe_free = pipe_free;
  end

  always_comb begin
    case (cmd.rd_sel)
      gdds_pkg::RD_PRV_X:   mem_rd_addr = {prv_bit, cur_x};
      gdds_pkg::RD_PRV_XM1: mem_rd_addr = {prv_bit, cur_x - CB'(1)};
      gdds_pkg::RD_PRV_XP1: mem_rd_addr = {prv_bit, cur_x + CB'(1)};
      gdds_pkg::RD_CUR_X:   mem_rd_addr = {cur_bit, cur_x};
      gdds_pkg::RD_CUR_XM1: mem_rd_addr = {cur_bit, cur_x - CB'(1)};
      gdds_pkg::RD_CUR_XM2: mem_rd_addr = {cur_bit, cur_x - CB'(2)};
      default:              mem_rd_addr = {cur_bit, cur_x};
    endcase
  end

  assign mem_rd_en   = cmd.rd_en;
  assign mem_wr_en   = cmd.wr_en;
  assign mem_wr_addr = {cur_bit, cur_x};
  assign mem_wr_data = cur_v;

  // Neighbour accumulation. Read data lands in the cycle after its address.
  logic [SB-1:0]                 acc_sum;
  logic [gdds_pkg::CNT_BITS-1:0] acc_cnt;
  logic [VB-1:0]                 acc_self;
  logic                          pend_valid;
  logic                          pend_self;
  logic [SB-1:0]                 sum_next;
  logic [gdds_pkg::CNT_BITS-1:0] cnt_next;
  logic [VB-1:0]                 self_next;

  always_comb begin
    sum_next  = acc_sum;
    cnt_next  = acc_cnt;
    self_next = acc_self;
    if (cmd.init_one) begin
      sum_next = SB'(cur_v);
      cnt_next = gdds_pkg::CNT_BITS'(1);
    end else if (cmd.init_zero) begin
      sum_next = '0;
      cnt_next = '0;
    end
    if (cmd.self_from_v) begin
      self_next = cur_v;
    end
    if (pend_valid) begin
      if (pend_self) begin
        self_next = mem_rd_data;
      end else begin
        sum_next = acc_sum + SB'(mem_rd_data);
        cnt_next = acc_cnt + gdds_pkg::CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    pend_self <= cmd.rd_to_self;
    acc_sum   <= sum_next;
    acc_cnt   <= cnt_next;
    acc_self  <= self_next;
  end

  // Blend pipeline; one blend in flight at a time. The start captures the
  // forwarded sums so that the last neighbour read may land in that cycle.
  logic v1, v2, v3, v4, v5;
  logic move;

  logic [SB-1:0]                 s1_sum;
  logic [gdds_pkg::CNT_BITS-1:0] s1_cnt;
  logic [VB-1:0]                 s1_self;
  logic [VB-1:0]                 s2_avg;
  logic [VB-1:0]                 s2_self;
  logic [MB-1:0]                 s3_p1;
  logic [MB-1:0]                 s3_p2;
  logic [MB-1:0]                 s4_mix;
  logic [PB-1:0]                 s5_prod;
  logic [CB-1:0]                 t_x;
  logic [RB-1:0]                 t_y;
  logic                          t_done;

  logic [SB+gdds_pkg::RECIP3_BITS-1:0] avg3_prod;
  logic [VB-1:0]                       avg_c;
  logic [WB:0]                         comp_w;
  logic [MB-1:0]                       p1_c;
  logic [MB:0]                         p2_c;
  logic [MB:0]                         mix_c;
  logic [PB-1:0]                       prod_c;
  logic [VB-1:0]                       res_c;

  assign avg3_prod = s1_sum * gdds_pkg::RECIP3;

  always_comb begin
    case (s1_cnt)
      3'd1:    avg_c = s1_sum[VB-1:0];
      3'd2:    avg_c = s1_sum[VB:1];
      3'd3:    avg_c = avg3_prod[gdds_pkg::RECIP3_SHIFT +: VB];
      3'd4:    avg_c = s1_sum[VB+1:2];
      default: avg_c = '0;
    endcase
  end

  assign comp_w = (WB+1)'(1 << WB) - {1'b0, self_weight};
  assign p1_c   = s2_self * self_weight;
  assign p2_c   = s2_avg * comp_w;
  assign mix_c  = {1'b0, s3_p1} + {1'b0, s3_p2};
  assign prod_c = s4_mix * decay_factor;
  assign res_c  = s5_prod[PB-1 -: VB];

  assign pipe_free = !(v1 || v2 || v3 || v4 || v5);
  assign move      = v5 && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= cmd.start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (v4) begin
        v5 <= 1'b1;
      end else if (move) begin
        v5 <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      s1_sum  <= sum_next;
      s1_cnt  <= cnt_next;
      s1_self <= self_next;
      case (cmd.tag)
        gdds_pkg::TAG_UP: begin
          t_x    <= cur_x;
          t_y    <= cur_y - RB'(1);
          t_done <= 1'b0;
        end
        gdds_pkg::TAG_LEFT: begin
          t_x    <= cur_x - CB'(1);
          t_y    <= cur_y;
          t_done <= 1'b0;
        end
        gdds_pkg::TAG_SELF: begin
          t_x    <= cur_x;
          t_y    <= cur_y;
          t_done <= 1'b1;
        end
        default: begin
          t_x    <= cur_x;
          t_y    <= cur_y;
          t_done <= 1'b0;
        end
      endcase
    end
    s2_avg  <= avg_c;
    s2_self <= s1_self;
    s3_p1   <= p1_c;
    s3_p2   <= p2_c[MB-1:0];
    s4_mix  <= mix_c[MB-1:0];
    if (v4) begin
      s5_prod <= prod_c;
    end
    if (move) begin
      out_cell_x     <= t_x;
      out_cell_y     <= t_y;
      out_new_value  <= (res_c < zero_floor) ? '0 : res_c;
      out_frame_done <= t_done;
    end
  end

`ifndef SYNTHESIS
  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> pipe_free)
    else $error("blend started while another blend is in flight");

  a_init_no_landing: assert property (@(posedge clk) disable iff (rst)
    (cmd.init_one || cmd.init_zero) |-> !pend_valid)
    else $error("accumulator cleared while a neighbour read was landing");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (v5 && !out_valid) |=> out_valid)
    else $error("finished blend did not reach an empty result register");

  a_no_read_on_write: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> !cmd.rd_en && !pend_valid)
    else $error("line store write overlapped a neighbour read");
`endif

endmodule

`default_nettype wire

// ----- rtl/grid_diffusion_decay_stencil_core.sv -----
// Four-neighbour diffusion stencil with decay, one grid frame in raster order.
// The sequencer takes no new cell while it works on the last one: neighbours
// come one a cycle from the single read port of the line store, and a blend
// waits for the one before it. A blend passes the pipeline registers to the
// result register, which can hold a result while the next cell is accepted; a
// stalled result output delays the next blend.
`timescale 1ns / 1ps
`default_nettype none

module grid_diffusion_decay_stencil_core (
  input  logic                               clk,
  input  logic                               rst,
  gdds_in_if.sink                            cell_in,
  gdds_out_if.source                         result_out,
  input  logic                               wr_en,
  input  logic [gdds_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  logic [gdds_pkg::CFG_DATA_BITS-1:0] wr_data
);

  // Reset clears control and configuration registers; the line store is not cleared.
  gdds_pkg::cmd_t    cmd;
  gdds_pkg::status_t status;

  logic                           mem_wr_en;
  logic [gdds_pkg::ADDR_BITS-1:0] mem_wr_addr;
  logic [gdds_pkg::VAL_BITS-1:0]  mem_wr_data;
  logic                           mem_rd_en;
  logic [gdds_pkg::ADDR_BITS-1:0] mem_rd_addr;
  logic [gdds_pkg::VAL_BITS-1:0]  mem_rd_data;

  gdds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cell_in.valid),
    .in_ready (cell_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  gdds_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cell_value     (cell_in.cell_value),
    .cfg_we         (wr_en),
    .cfg_index      (wr_index),
    .cfg_data       (wr_data),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data),
    .out_valid      (result_out.valid),
    .out_ready      (result_out.ready),
    .out_cell_x     (result_out.cell_x),
    .out_cell_y     (result_out.cell_y),
    .out_new_value  (result_out.new_value),
    .out_frame_done (result_out.frame_done)
  );

  // Two rows of cells: even rows in the lower half, odd rows in the upper.
  gdds_ram #(
    .WIDTH (gdds_pkg::VAL_BITS),
    .DEPTH (gdds_pkg::LINE_DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire
